// File: design/tsv_pkg.sv
// ----------------------------------------------------------------------------
// tsv_pkg
// shared types and constants of the triple sensor voter
// ----------------------------------------------------------------------------
package tsv_pkg;

    localparam int VOTE_BITS   = 10;
    localparam int COUNT_BITS  = 2;
    localparam int LIMIT_BITS  = 10;
    localparam int SPREAD_BITS = 17;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET   = 10'd50;
    localparam logic [7:0]             NO_GOOD_VALUE = 8'hFF;
    localparam logic [6:0]             PERCENT       = 7'd100;
    localparam logic [SPREAD_BITS-1:0] SPREAD_MAX    = 17'h1FFFF;
    localparam logic [1:0]             GOOD_ALL      = 2'd3;

    // register index taken from paddr word bit
    localparam logic REG_JUMP_LIMIT = 1'b0;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic div_step;
        logic out_load;
    } tsv_cmd_t;

    typedef struct packed {
        logic div_last;
    } tsv_sts_t;

endpackage

// File: design/triple_sensor_vote_with_jump_check.sv
// ----------------------------------------------------------------------------
// triple_sensor_vote_with_jump_check
// votes three redundant pressure samples with a per-sensor jump check
// sequence per set: evaluate, SAMPLE_BITS + 7 radix-2 divider steps and
// output load, which waits until the output register is free
// a new set is accepted only in idle, after the previous result has been
// loaded into the output register
// reset clears the previous samples, the first set is never flagged,
// and jump_limit returns to 50
// ----------------------------------------------------------------------------
module triple_sensor_vote_with_jump_check #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [SAMPLE_BITS-1:0]               s_sample_a,
    input  logic [SAMPLE_BITS-1:0]               s_sample_b,
    input  logic [SAMPLE_BITS-1:0]               s_sample_c,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tsv_pkg::VOTE_BITS-1:0]        m_voted_value,
    output logic [tsv_pkg::COUNT_BITS-1:0]       m_good_count,
    output logic                                 m_jump_a,
    output logic                                 m_jump_b,
    output logic                                 m_jump_c,
    output logic                                 m_depth_alarm,
    output logic [tsv_pkg::SPREAD_BITS-1:0]      m_spread_percent,
    output logic                                 m_spread_invalid,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tsv_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [tsv_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [tsv_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);

    tsv_pkg::tsv_cmd_t cmd;
    tsv_pkg::tsv_sts_t sts;

    logic [tsv_pkg::LIMIT_BITS-1:0] jump_limit_reg;
    logic                           reg_sel;

    // word index of the register
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jump_limit_reg <= tsv_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && (reg_sel == tsv_pkg::REG_JUMP_LIMIT)) begin
            jump_limit_reg <= pwdata[tsv_pkg::LIMIT_BITS-1:0];
        end
    end

    always_comb begin
        if (reg_sel == tsv_pkg::REG_JUMP_LIMIT) begin
            prdata = tsv_pkg::APB_DATA_BITS'(jump_limit_reg);
        end else begin
            prdata = '0;
        end
    end

    tsv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tsv_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_sample_a       (s_sample_a),
        .s_sample_b       (s_sample_b),
        .s_sample_c       (s_sample_c),
        .jump_limit       (jump_limit_reg),
        .m_voted_value    (m_voted_value),
        .m_good_count     (m_good_count),
        .m_jump_a         (m_jump_a),
        .m_jump_b         (m_jump_b),
        .m_jump_c         (m_jump_c),
        .m_depth_alarm    (m_depth_alarm),
        .m_spread_percent (m_spread_percent),
        .m_spread_invalid (m_spread_invalid)
    );

endmodule

// File: design/tsv_ctrl.sv
// ----------------------------------------------------------------------------
// tsv_ctrl
// sequencer for one sample set: load, evaluate, divide, hand over result
// ----------------------------------------------------------------------------
module tsv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  tsv_pkg::tsv_sts_t sts,
    output tsv_pkg::tsv_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait until the output register is free
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: design/tsv_datapath.sv
// ----------------------------------------------------------------------------
// tsv_datapath
// jump check, vote, min/max and radix-2 restoring divider for the spread
// ----------------------------------------------------------------------------
module tsv_datapath #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tsv_pkg::tsv_cmd_t                   cmd,
    output tsv_pkg::tsv_sts_t                   sts,
    input  logic [SAMPLE_BITS-1:0]              s_sample_a,
    input  logic [SAMPLE_BITS-1:0]              s_sample_b,
    input  logic [SAMPLE_BITS-1:0]              s_sample_c,
    input  logic [tsv_pkg::LIMIT_BITS-1:0]      jump_limit,
    output logic [tsv_pkg::VOTE_BITS-1:0]       m_voted_value,
    output logic [tsv_pkg::COUNT_BITS-1:0]      m_good_count,
    output logic                                m_jump_a,
    output logic                                m_jump_b,
    output logic                                m_jump_c,
    output logic                                m_depth_alarm,
    output logic [tsv_pkg::SPREAD_BITS-1:0]     m_spread_percent,
    output logic                                m_spread_invalid
);

    localparam int SB   = SAMPLE_BITS;
    // 100 * (max - min) fits in SB + 7 bits
    localparam int NW   = SB + 7;
    localparam int CW   = (SB > tsv_pkg::LIMIT_BITS) ? SB : tsv_pkg::LIMIT_BITS;
    localparam int QW   = (NW > tsv_pkg::SPREAD_BITS) ? NW : tsv_pkg::SPREAD_BITS;
    localparam int CNTW = $clog2(NW);

    logic [SB-1:0]   a_reg, b_reg, c_reg;
    logic [SB-1:0]   prev_a_reg, prev_b_reg, prev_c_reg;
    logic            have_prev_reg;
    logic            ja_reg, jb_reg, jc_reg;
    logic [SB-1:0]   voted_reg;
    logic [SB-1:0]   lo_reg;
    logic            invalid_reg;
    logic [NW-1:0]   num_reg;
    logic [SB:0]     rem_reg;
    logic [CNTW-1:0] cnt_reg;

    // evaluation of the loaded set
    logic [SB-1:0] diff_a, diff_b, diff_c;
    logic          ja, jb, jc;
    logic [SB-1:0] mn_ab, mx_ab, median, lo, hi;
    logic [SB:0]   sum_ab, sum_ac, sum_bc;
    logic [SB-1:0] voted;
    logic [NW-1:0] spread_num;

    always_comb begin
        diff_a = (a_reg > prev_a_reg) ? a_reg - prev_a_reg : prev_a_reg - a_reg;
        diff_b = (b_reg > prev_b_reg) ? b_reg - prev_b_reg : prev_b_reg - b_reg;
        diff_c = (c_reg > prev_c_reg) ? c_reg - prev_c_reg : prev_c_reg - c_reg;
        ja = have_prev_reg && (CW'(diff_a) > CW'(jump_limit));
        jb = have_prev_reg && (CW'(diff_b) > CW'(jump_limit));
        jc = have_prev_reg && (CW'(diff_c) > CW'(jump_limit));

        mn_ab  = (a_reg < b_reg) ? a_reg : b_reg;
        mx_ab  = (a_reg > b_reg) ? a_reg : b_reg;
        median = (mx_ab < c_reg) ? mx_ab : c_reg;
        if (mn_ab > median) begin
            median = mn_ab;
        end
        lo = (mn_ab < c_reg) ? mn_ab : c_reg;
        hi = (mx_ab > c_reg) ? mx_ab : c_reg;

        sum_ab = {1'b0, a_reg} + {1'b0, b_reg};
        sum_ac = {1'b0, a_reg} + {1'b0, c_reg};
        sum_bc = {1'b0, b_reg} + {1'b0, c_reg};

        case ({ja, jb, jc})
            3'b000:  voted = median;
            3'b100:  voted = sum_bc[SB:1];
            3'b010:  voted = sum_ac[SB:1];
            3'b001:  voted = sum_ab[SB:1];
            3'b011:  voted = a_reg;
            3'b101:  voted = b_reg;
            3'b110:  voted = c_reg;
            default: voted = SB'(tsv_pkg::NO_GOOD_VALUE);
        endcase

        spread_num = NW'(hi - lo) * NW'(tsv_pkg::PERCENT);
    end

    // one quotient bit per step, quotient shifts into num_reg
    logic [SB:0] rem_shift;
    logic        q_bit;
    logic [SB:0] rem_sub;

    always_comb begin
        rem_shift = {rem_reg[SB-1:0], num_reg[NW-1]};
        q_bit     = (rem_shift >= {1'b0, lo_reg});
        rem_sub   = rem_shift - {1'b0, lo_reg};
    end

    assign sts.div_last = (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_a_reg    <= '0;
            prev_b_reg    <= '0;
            prev_c_reg    <= '0;
            have_prev_reg <= 1'b0;
        end else if (cmd.prep) begin
            prev_a_reg    <= a_reg;
            prev_b_reg    <= b_reg;
            prev_c_reg    <= c_reg;
            have_prev_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            a_reg <= s_sample_a;
            b_reg <= s_sample_b;
            c_reg <= s_sample_c;
        end
        if (cmd.prep) begin
            ja_reg      <= ja;
            jb_reg      <= jb;
            jc_reg      <= jc;
            voted_reg   <= voted;
            lo_reg      <= lo;
            invalid_reg <= (lo == '0);
            num_reg     <= spread_num;
            rem_reg     <= '0;
            cnt_reg     <= CNTW'(NW - 1);
        end else if (cmd.div_step) begin
            rem_reg <= q_bit ? rem_sub : rem_shift;
            num_reg <= {num_reg[NW-2:0], q_bit};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // output register
    logic [QW-1:0] quot_ext;
    logic [tsv_pkg::SPREAD_BITS-1:0] spread_sat;

    always_comb begin
        quot_ext = QW'(num_reg);
        if (invalid_reg) begin
            spread_sat = '0;
        end else if (quot_ext > QW'(tsv_pkg::SPREAD_MAX)) begin
            spread_sat = tsv_pkg::SPREAD_MAX;
        end else begin
            spread_sat = tsv_pkg::SPREAD_BITS'(quot_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_voted_value    <= tsv_pkg::VOTE_BITS'(voted_reg);
            m_good_count     <= tsv_pkg::GOOD_ALL - (tsv_pkg::COUNT_BITS'(ja_reg)
                                + tsv_pkg::COUNT_BITS'(jb_reg)
                                + tsv_pkg::COUNT_BITS'(jc_reg));
            m_jump_a         <= ja_reg;
            m_jump_b         <= jb_reg;
            m_jump_c         <= jc_reg;
            m_depth_alarm    <= ja_reg | jb_reg | jc_reg;
            m_spread_percent <= spread_sat;
            m_spread_invalid <= invalid_reg;
        end
    end

endmodule
